@@ rtl/gwtc_pkg.sv @@
// Types and constants for the GPS week/time-of-week to calendar converter.
// Used by: gps_week_time_to_calendar. No dependencies.

package gwtc_pkg;

    // Input transfer: week count and milliseconds into the week
    typedef struct packed {
        logic [12:0] gps_week;
        logic [29:0] ms_of_week;
    } gwtc_in_t;

    // Result transfer: calendar date, time of day and range flag
    typedef struct packed {
        logic [11:0] year;
        logic [8:0]  day_of_year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] milli_of_minute;
        logic        out_of_range;
    } gwtc_out_t;

    // Range limits
    localparam logic [29:0] MS_PER_WEEK    = 30'd604800000;
    localparam logic [12:0] MAX_WEEK       = 13'd6260;

    // Time constants
    localparam logic [26:0] MS_PER_DAY     = 27'd86400000;
    localparam logic [15:0] MS_PER_MINUTE  = 16'd60000;
    localparam logic [5:0]  MIN_PER_HOUR   = 6'd60;

    // Day numbering: GPS epoch MJD 44244 rebased to 1 January 1901 (MJD 15385)
    localparam logic [16:0] DAY_OFFSET     = 17'd28859;
    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [11:0] BASE_YEAR      = 12'd1901;
    // Cycle that holds 2097..2100; its fourth year (2100) is not a leap year
    localparam logic [5:0]  CENTURY_CYCLE  = 6'd49;

    // Reciprocals: floor(x/d) = (x * ceil(2^k/d)) >> k, exact over the x width used
    // minute of day from ms of day (x < 2^27)
    localparam logic [27:0] MINUTE_RECIP   = 28'd146601551;
    localparam int          MINUTE_SHIFT   = 43;
    // four-year cycle from day number (x < 2^17)
    localparam logic [17:0] CYCLE_RECIP    = 18'd183735;
    localparam int          CYCLE_SHIFT    = 28;
    // hour from minute of day (x < 2^11)
    localparam logic [11:0] HOUR_RECIP     = 12'd2185;
    localparam int          HOUR_SHIFT     = 17;

    // Day of year on which each month ends
    localparam logic [8:0] MONTH_END_COMMON [0:11] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] MONTH_END_LEAP [0:11] = '{
        9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

endpackage

@@ rtl/gps_week_time_to_calendar.sv @@
// GPS week and time of week to calendar date and time of day, six-stage pipeline.
// Depends on: gwtc_pkg (port structs, constants, month tables).
//
//  channel  | ports                 | transfer when
//  ---------+-----------------------+---------------------------
//  command  | start, busy, cmd      | start high and busy low
//  result   | done, res             | done high (one cycle each)
//
// Each command returns one result from the last stage; one command can
// enter every cycle. The reciprocal multipliers for the minute and
// four-year-cycle splits share a stage, and the month table search has a
// stage of its own. busy stays low: the result side never holds off.
// Reset clears only the stage valid bits; data registers carry no reset.

module gps_week_time_to_calendar (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  gwtc_pkg::gwtc_in_t cmd,
    output logic               done,
    output gwtc_pkg::gwtc_out_t res
);

    // Stage valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg;

    // Stage 1: captured command
    logic [12:0] s1_week_reg;
    logic [29:0] s1_ms_reg;

    // Stage 2: day number and ms of day
    logic        s2_oor_reg;
    logic [16:0] s2_days_reg;
    logic [26:0] s2_msd_reg;
    logic        s2_oor_next;
    logic [16:0] s2_days_next;
    logic [26:0] s2_msd_next;
    logic [2:0]  dow_next;

    // Stage 3: reciprocal products
    logic        s3_oor_reg;
    logic [16:0] s3_days_reg;
    logic [26:0] s3_msd_reg;
    logic [5:0]  s3_cycles_reg;
    logic [10:0] s3_mod_reg;
    logic [54:0] mod_prod;
    logic [34:0] cyc_prod;

    // Stage 4: remainders and hour
    logic        s4_oor_reg;
    logic [5:0]  s4_cycles_reg;
    logic [10:0] s4_left_reg;
    logic [10:0] s4_mod_reg;
    logic [15:0] s4_milli_reg;
    logic [4:0]  s4_hour_reg;
    logic [16:0] cyc_days;
    logic [26:0] mod_ms;
    logic [22:0] hour_prod;
    logic [16:0] s4_left_next;
    logic [26:0] s4_milli_next;

    // Stage 5: year, day of year, minute
    logic        s5_oor_reg;
    logic [11:0] s5_year_reg;
    logic [8:0]  s5_doy_reg;
    logic        s5_leap_reg;
    logic [4:0]  s5_hour_reg;
    logic [5:0]  s5_minute_reg;
    logic [15:0] s5_milli_reg;
    logic [1:0]  dy_next;
    logic [10:0] year_off_next;
    logic [11:0] s5_year_next;
    logic [10:0] doy_base_next;
    logic [8:0]  s5_doy_next;
    logic [10:0] hour_min;
    logic [10:0] s5_minute_next;

    // Stage 6: output register
    gwtc_pkg::gwtc_out_t s6_res_reg;
    gwtc_pkg::gwtc_out_t s6_res_next;
    logic [3:0]  month_next;
    logic [8:0]  month_base_next;
    logic [8:0]  dom_next;

    // Advance valid bits; the pipeline never stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 2: range check, day of week by threshold count, day number
    always_comb
    begin
        s2_oor_next = (s1_ms_reg >= gwtc_pkg::MS_PER_WEEK) || (s1_week_reg > gwtc_pkg::MAX_WEEK);
        dow_next = 3'd0;
        for (int k = 1; k < 7; k++)
        begin
            if (s1_ms_reg >= 30'(k) * 30'(gwtc_pkg::MS_PER_DAY))
            begin
                dow_next = dow_next + 3'd1;
            end
        end
        s2_msd_next = 27'(s1_ms_reg - 30'(dow_next) * 30'(gwtc_pkg::MS_PER_DAY));
        s2_days_next = ({1'b0, s1_week_reg, 3'b000} - {4'b0000, s1_week_reg})
                     + 17'(dow_next) + gwtc_pkg::DAY_OFFSET;
    end

    // Stage 3: minute of day and four-year cycle by reciprocal multiply
    assign mod_prod = 55'(s2_msd_reg) * 55'(gwtc_pkg::MINUTE_RECIP);
    assign cyc_prod = 35'(s2_days_reg) * 35'(gwtc_pkg::CYCLE_RECIP);

    // Stage 4: day within cycle, ms within minute, hour
    assign cyc_days      = 17'(s3_cycles_reg) * 17'(gwtc_pkg::DAYS_PER_CYCLE);
    assign mod_ms        = 27'(s3_mod_reg) * 27'(gwtc_pkg::MS_PER_MINUTE);
    assign hour_prod     = 23'(s3_mod_reg) * 23'(gwtc_pkg::HOUR_RECIP);
    assign s4_left_next  = s3_days_reg - cyc_days;
    assign s4_milli_next = s3_msd_reg - mod_ms;

    // Stage 5: year within cycle, day of year, leap flag, minute of hour
    always_comb
    begin
        dy_next = 2'd0;
        for (int k = 1; k < 4; k++)
        begin
            if (s4_left_reg >= 11'(k) * 11'(gwtc_pkg::DAYS_PER_YEAR))
            begin
                dy_next = dy_next + 2'd1;
            end
        end
        doy_base_next  = 11'(dy_next) * 11'(gwtc_pkg::DAYS_PER_YEAR);
        s5_doy_next    = 9'(s4_left_reg - doy_base_next + 11'd1);
        year_off_next  = {3'b000, s4_cycles_reg, 2'b00} + 11'(dy_next);
        s5_year_next   = gwtc_pkg::BASE_YEAR + 12'(year_off_next);
        hour_min       = 11'(s4_hour_reg) * 11'(gwtc_pkg::MIN_PER_HOUR);
        s5_minute_next = s4_mod_reg - hour_min;
    end

    // Stage 6: month search over month-end table, zero fields when out of range
    always_comb
    begin
        month_next      = 4'd1;
        month_base_next = 9'd0;
        for (int m = 0; m < 11; m++)
        begin
            if (s5_leap_reg ? (s5_doy_reg > gwtc_pkg::MONTH_END_LEAP[m])
                            : (s5_doy_reg > gwtc_pkg::MONTH_END_COMMON[m]))
            begin
                month_next      = month_next + 4'd1;
                month_base_next = s5_leap_reg ? gwtc_pkg::MONTH_END_LEAP[m]
                                              : gwtc_pkg::MONTH_END_COMMON[m];
            end
        end
        dom_next = s5_doy_reg - month_base_next;

        s6_res_next = '0;
        if (s5_oor_reg)
        begin
            s6_res_next.out_of_range = 1'b1;
        end
        else
        begin
            s6_res_next.year            = s5_year_reg;
            s6_res_next.day_of_year     = s5_doy_reg;
            s6_res_next.month           = month_next;
            s6_res_next.day_of_month    = dom_next[4:0];
            s6_res_next.hour            = s5_hour_reg;
            s6_res_next.minute          = s5_minute_reg;
            s6_res_next.milli_of_minute = s5_milli_reg;
        end
    end

    // Hold data registers; valid bits mark which entries mean anything
    always_ff @(posedge clk)
    begin
        s1_week_reg   <= cmd.gps_week;
        s1_ms_reg     <= cmd.ms_of_week;

        s2_oor_reg    <= s2_oor_next;
        s2_days_reg   <= s2_days_next;
        s2_msd_reg    <= s2_msd_next;

        s3_oor_reg    <= s2_oor_reg;
        s3_days_reg   <= s2_days_reg;
        s3_msd_reg    <= s2_msd_reg;
        s3_mod_reg    <= mod_prod[gwtc_pkg::MINUTE_SHIFT +: 11];
        s3_cycles_reg <= cyc_prod[gwtc_pkg::CYCLE_SHIFT +: 6];

        s4_oor_reg    <= s3_oor_reg;
        s4_cycles_reg <= s3_cycles_reg;
        s4_left_reg   <= s4_left_next[10:0];
        s4_mod_reg    <= s3_mod_reg;
        s4_milli_reg  <= s4_milli_next[15:0];
        s4_hour_reg   <= hour_prod[gwtc_pkg::HOUR_SHIFT +: 5];

        s5_oor_reg    <= s4_oor_reg;
        s5_year_reg   <= s5_year_next;
        s5_doy_reg    <= s5_doy_next;
        s5_leap_reg   <= (dy_next == 2'd3) && (s4_cycles_reg != gwtc_pkg::CENTURY_CYCLE);
        s5_hour_reg   <= s4_hour_reg;
        s5_minute_reg <= s5_minute_next[5:0];
        s5_milli_reg  <= s4_milli_reg;

        s6_res_reg    <= s6_res_next;
    end

    assign busy = 1'b0;
    assign done = s6_valid_reg;
    assign res  = s6_res_reg;

endmodule
